// ===== rtl/bmm_pkg.sv =====
package bmm_pkg;

	// item and result field widths
	localparam int OP_W    = 2;
	localparam int BATCH_W = 2;
	localparam int IDX_W   = 4;
	localparam int ELEM_W  = 16;
	localparam int PROD_W  = 38;

	// register port
	localparam int CFG_AW = 5;
	localparam int CFG_DW = 32;
	localparam int DIM_W  = 5;
	localparam int NB_W   = 3;
	localparam int BC_W   = 2;

	localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
	localparam logic [OP_W-1:0] OP_READ    = 2'd2;

	localparam logic [BC_W-1:0] BC_NONE = 2'd0;
	localparam logic [BC_W-1:0] BC_A    = 2'd1;
	localparam logic [BC_W-1:0] BC_B    = 2'd2;

	localparam logic [2:0] REG_ROWS  = 3'd0;
	localparam logic [2:0] REG_INNER = 3'd1;
	localparam logic [2:0] REG_COLS  = 3'd2;
	localparam logic [2:0] REG_BATCH = 3'd3;
	localparam logic [2:0] REG_BCAST = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/bmm_item_if.sv =====
interface bmm_item_if
	import bmm_pkg::*;
	();
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          operation;
	logic [BATCH_W-1:0]       batch_index;
	logic [IDX_W-1:0]         row_index;
	logic [IDX_W-1:0]         col_index;
	logic signed [ELEM_W-1:0] element_value;

	modport source (
		output valid, operation, batch_index, row_index, col_index, element_value,
		input  ready
	);
	modport sink (
		input  valid, operation, batch_index, row_index, col_index, element_value,
		output ready
	);
endinterface

// ===== rtl/bmm_result_if.sv =====
interface bmm_result_if
	import bmm_pkg::*;
	();
	logic                     valid;
	logic                     ready;
	logic signed [PROD_W-1:0] product_value;
	logic                     out_of_range;

	modport source (
		output valid, product_value, out_of_range,
		input  ready
	);
	modport sink (
		input  valid, product_value, out_of_range,
		output ready
	);
endinterface

// ===== rtl/batched_matmul_broadcast.sv =====
// batched matrix multiply with batch broadcast
// item channel: operation 0 writes an element of A (batch, row, inner),
// operation 1 writes an element of B (batch, inner, col), operation 2 reads
// one output element; operation 3 is dropped. result channel: one word per
// read, the full-width dot product and an out_of_range flag (value zero).
// writes give no result. a read occupies the block until its result is
// loaded: after acceptance one multiply-accumulate per cycle walks the
// inner dimension over the A and B element memories (one registered read
// port each), then the multiplier and accumulator registers drain.
// out-of-range reads and inner_k of 0 skip the walk.
// one item is in work at a time; the result register holds a finished word
// while the next item is taken, so a stalled receiver only stops a read
// that completes while the previous result is still unclaimed.
// the user must write the registers over the apb port only while the block
// is idle, which the block does not enforce; sizes above the store limits
// saturate. reset clears the registers to 1/1/1/1/0 and the control state;
// the element memories are not cleared and must be written before they are read.
module batched_matmul_broadcast
	import bmm_pkg::*;
#(
	parameter int MAX_ROWS   = 16,
	parameter int MAX_INNER  = 16,
	parameter int MAX_COLS   = 16,
	parameter int MAX_BATCH  = 4,
	parameter int DATA_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready,
	bmm_item_if.sink          item,
	bmm_result_if.source      result
);

	localparam int A_DEPTH = MAX_BATCH * MAX_ROWS * MAX_INNER;
	localparam int B_DEPTH = MAX_BATCH * MAX_INNER * MAX_COLS;
	localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
	localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
	localparam int KCW     = $clog2(MAX_INNER + 1);

	// registers
	logic [DIM_W-1:0] rows_m_q, inner_k_q, cols_n_q;
	logic [NB_W-1:0]  batch_count_q;
	logic [BC_W-1:0]  broadcast_mode_q;

	logic cfg_we;
	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_m_q         <= DIM_W'(1);
			inner_k_q        <= DIM_W'(1);
			cols_n_q         <= DIM_W'(1);
			batch_count_q    <= NB_W'(1);
			broadcast_mode_q <= BC_NONE;
		end else if (cfg_we) begin
			case (paddr[4:2])
				REG_ROWS:  rows_m_q         <= pwdata[DIM_W-1:0];
				REG_INNER: inner_k_q        <= pwdata[DIM_W-1:0];
				REG_COLS:  cols_n_q         <= pwdata[DIM_W-1:0];
				REG_BATCH: batch_count_q    <= pwdata[NB_W-1:0];
				REG_BCAST: broadcast_mode_q <= pwdata[BC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_ROWS:  prdata = CFG_DW'(rows_m_q);
			REG_INNER: prdata = CFG_DW'(inner_k_q);
			REG_COLS:  prdata = CFG_DW'(cols_n_q);
			REG_BATCH: prdata = CFG_DW'(batch_count_q);
			REG_BCAST: prdata = CFG_DW'(broadcast_mode_q);
			default:   prdata = '0;
		endcase
	end

	// saturated sizes
	int m_sat, n_sat, nb_sat, k_sat;
	always_comb begin
		m_sat  = (int'(rows_m_q) > MAX_ROWS) ? MAX_ROWS : int'(rows_m_q);
		n_sat  = (int'(cols_n_q) > MAX_COLS) ? MAX_COLS : int'(cols_n_q);
		nb_sat = (int'(batch_count_q) > MAX_BATCH) ? MAX_BATCH : int'(batch_count_q);
		k_sat  = (int'(inner_k_q) > MAX_INNER) ? MAX_INNER : int'(inner_k_q);
	end

	// item decode
	logic accept, is_read, rd_oor, a_we, b_we;
	logic signed [DATA_WIDTH-1:0] elem;
	logic [A_AW-1:0] a_waddr, a_raddr;
	logic [B_AW-1:0] b_waddr, b_raddr;

	assign accept  = item.valid & item.ready;
	assign is_read = item.operation == OP_READ;
	assign rd_oor  = (int'(item.batch_index) >= nb_sat) || (int'(item.row_index) >= m_sat)
		|| (int'(item.col_index) >= n_sat);
	assign elem    = DATA_WIDTH'(item.element_value);
	assign a_we    = accept && item.operation == OP_WRITE_A
		&& int'(item.batch_index) < MAX_BATCH && int'(item.row_index) < MAX_ROWS
		&& int'(item.col_index) < MAX_INNER;
	assign b_we    = accept && item.operation == OP_WRITE_B
		&& int'(item.batch_index) < MAX_BATCH && int'(item.row_index) < MAX_INNER
		&& int'(item.col_index) < MAX_COLS;
	assign a_waddr = A_AW'((int'(item.batch_index) * MAX_ROWS + int'(item.row_index))
		* MAX_INNER + int'(item.col_index));
	assign b_waddr = B_AW'((int'(item.batch_index) * MAX_INNER + int'(item.row_index))
		* MAX_COLS + int'(item.col_index));

	// read job state
	state_t state_q, state_d;
	logic [BATCH_W-1:0] ba_q, bb_q;
	logic [IDX_W-1:0]   row_q, col_q;
	logic [KCW-1:0]     k_cnt_q, k_lim_q;
	logic               issue_done_q, oor_q;
	logic signed [PROD_W-1:0] acc_q;

	logic issue_en, last_issue, out_load;
	logic rd_v_s1, rd_last_s1, prod_v_s2, last_s2;
	logic signed [DATA_WIDTH-1:0]   a_rd_s1, b_rd_s1;
	logic signed [2*DATA_WIDTH-1:0] prod_s2;

	logic out_valid_q, out_oor_q;
	logic signed [PROD_W-1:0] out_value_q;

	assign last_issue = KCW'(k_cnt_q + KCW'(1)) == k_lim_q;
	assign a_raddr = A_AW'((int'(ba_q) * MAX_ROWS + int'(row_q)) * MAX_INNER + int'(k_cnt_q));
	assign b_raddr = B_AW'((int'(bb_q) * MAX_INNER + int'(k_cnt_q)) * MAX_COLS + int'(col_q));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_read) begin
					if (rd_oor || k_sat == 0)
						state_d = ST_DONE;
					else
						state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (prod_v_s2 && last_s2)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || result.ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item.ready = 1'b0;
		issue_en   = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: item.ready = 1'b1;
			ST_RUN:  issue_en = !issue_done_q;
			ST_DONE: out_load = !out_valid_q || result.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			issue_done_q <= 1'b0;
			k_cnt_q      <= '0;
			rd_v_s1      <= 1'b0;
			rd_last_s1   <= 1'b0;
			prod_v_s2    <= 1'b0;
			last_s2      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_v_s1    <= issue_en;
			rd_last_s1 <= issue_en && last_issue;
			prod_v_s2  <= rd_v_s1;
			last_s2    <= rd_last_s1;
			if (accept && is_read) begin
				k_cnt_q      <= '0;
				issue_done_q <= 1'b0;
			end else if (issue_en) begin
				k_cnt_q <= KCW'(k_cnt_q + KCW'(1));
				if (last_issue)
					issue_done_q <= 1'b1;
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	// job payload, accumulator and result word
	always_ff @(posedge clk) begin
		prod_s2 <= a_rd_s1 * b_rd_s1;
		if (accept && is_read) begin
			ba_q    <= (broadcast_mode_q == BC_A) ? '0 : item.batch_index;
			bb_q    <= (broadcast_mode_q == BC_B) ? '0 : item.batch_index;
			row_q   <= item.row_index;
			col_q   <= item.col_index;
			k_lim_q <= KCW'(k_sat);
			oor_q   <= rd_oor;
			acc_q   <= '0;
		end else if (prod_v_s2) begin
			acc_q <= acc_q + PROD_W'(prod_s2);
		end
		if (out_load) begin
			out_value_q <= oor_q ? '0 : acc_q;
			out_oor_q   <= oor_q;
		end
	end

	// element memories
	logic [DATA_WIDTH-1:0] a_mem [A_DEPTH];
	logic [DATA_WIDTH-1:0] b_mem [B_DEPTH];

	always_ff @(posedge clk) begin
		if (a_we)
			a_mem[a_waddr] <= elem;
		a_rd_s1 <= a_mem[a_raddr];
	end

	always_ff @(posedge clk) begin
		if (b_we)
			b_mem[b_waddr] <= elem;
		b_rd_s1 <= b_mem[b_raddr];
	end

	assign result.valid         = out_valid_q;
	assign result.product_value = out_value_q;
	assign result.out_of_range  = out_oor_q;

endmodule
